// ----- src/cptt_pkg.sv -----
// ----------------------------------------------------------------------------
// cptt_pkg
// Shared types and constants for the cuckoo pointer translation table.
// ----------------------------------------------------------------------------
package cptt_pkg;

    localparam int DEPTH_DEFAULT    = 1024;
    localparam int KEY_BITS_DEFAULT = 32;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int ROUNDS_W = 4;

    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 4'd5;

    localparam int HASH_SHR = 4;
    localparam int HASH_MUL_SHL = 5;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [1:0] HASH_DIRECT = 2'd0;
    localparam logic [1:0] HASH_SHIFT  = 2'd1;
    localparam logic [1:0] HASH_MUL    = 2'd2;
    localparam logic [1:0] PROBE_END   = 2'd3;

    localparam logic [1:0] RES_MISS = 2'd0;
    localparam logic [1:0] RES_HIT  = 2'd1;
    localparam logic [1:0] RES_OK   = 2'd2;
    localparam logic [1:0] RES_OVF  = 2'd3;

    typedef struct packed {
        logic               op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] new_value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] found_value;
        logic               insert_ok;
        logic               overflow;
        logic [KEY_W-1:0]   dropped_key;
        logic [VALUE_W-1:0] dropped_value;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [1:0] probe;
        logic       wr_en;
        logic       swap;
        logic       clr_step;
        logic       res_load;
        logic [1:0] res_code;
    } cmd_t;

    typedef struct packed {
        logic in_op;
        logic in_key_zero;
        logic key_match;
        logic slot_empty;
        logic clr_last;
    } sts_t;

endpackage

// ----- src/cptt_datapath.sv -----
// ----------------------------------------------------------------------------
// cptt_datapath
// Slot memory, carried entry, hash address generation and result register.
// ----------------------------------------------------------------------------
module cptt_datapath
    import cptt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT,
    parameter int KEY_BITS    = KEY_BITS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t request,
    input  cmd_t cmd,
    output sts_t sts,
    output logic done,
    output rsp_t result
);

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int SKW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int XW  = SKW + IW + HASH_SHR;

    function automatic logic [IW-1:0] slot_hash(input logic [SKW-1:0] k,
                                                input logic [1:0] sel);
        logic [XW-1:0] ext;
        logic [IW-1:0] lo;
        logic [IW-1:0] h;
        ext = {{(IW+HASH_SHR){1'b0}}, k};
        lo  = ext[IW-1:0];
        unique case (sel)
            HASH_SHIFT: h = ext[IW+HASH_SHR-1:HASH_SHR];
            HASH_MUL:   h = (lo << HASH_MUL_SHL) - lo;
            default:    h = lo;
        endcase
        return h;
    endfunction

    logic [SKW-1:0]     key_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] val_mem [TABLE_DEPTH];

    logic [SKW-1:0]     ck_reg, ck_next;
    logic [VALUE_W-1:0] cv_reg, cv_next;
    logic [SKW-1:0]     rkey_reg;
    logic [VALUE_W-1:0] rval_reg;
    logic [IW-1:0]      addr_reg;
    logic [IW-1:0]      clr_addr_reg, clr_addr_next;
    logic [IW-1:0]      raddr;
    logic [IW-1:0]      waddr;
    logic               mem_we;
    logic [SKW-1:0]     wkey;
    logic [VALUE_W-1:0] wval;
    logic               done_reg;
    rsp_t               rsp_reg, rsp_next;

    assign raddr = slot_hash(ck_reg, cmd.probe);

    always_comb
    begin
        ck_next = ck_reg;
        cv_next = cv_reg;
        if (cmd.load)
        begin
            ck_next = request.key[SKW-1:0];
            cv_next = request.new_value;
        end
        else if (cmd.swap)
        begin
            ck_next = rkey_reg;
            cv_next = rval_reg;
        end
    end

    always_comb
    begin
        mem_we = cmd.clr_step | cmd.wr_en;
        if (cmd.clr_step)
        begin
            waddr = clr_addr_reg;
            wkey  = '0;
            wval  = '0;
        end
        else
        begin
            waddr = addr_reg;
            wkey  = ck_reg;
            wval  = cv_reg;
        end
    end

    assign clr_addr_next = cmd.clr_step ? clr_addr_reg + IW'(1) : clr_addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[waddr] <= wkey;
            val_mem[waddr] <= wval;
        end
        if (cmd.rd_en)
        begin
            rkey_reg <= key_mem[raddr];
            rval_reg <= val_mem[raddr];
        end
    end

    always_comb
    begin
        rsp_next = '0;
        case (cmd.res_code)
            RES_HIT:
            begin
                rsp_next.hit         = 1'b1;
                rsp_next.found_value = rval_reg;
            end
            RES_OK:
            begin
                rsp_next.insert_ok = 1'b1;
            end
            RES_OVF:
            begin
                rsp_next.overflow      = 1'b1;
                rsp_next.dropped_key   = KEY_W'(ck_reg);
                rsp_next.dropped_value = cv_reg;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ck_reg <= ck_next;
        cv_reg <= cv_next;
        if (cmd.rd_en)
        begin
            addr_reg <= raddr;
        end
        if (cmd.res_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            done_reg     <= cmd.res_load;
        end
    end

    assign sts.in_op       = request.op;
    assign sts.in_key_zero = (request.key[SKW-1:0] == '0);
    assign sts.key_match   = (rkey_reg == ck_reg);
    assign sts.slot_empty  = (rkey_reg == '0);
    assign sts.clr_last    = (clr_addr_reg == '1);

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

// ----- src/cptt_ctrl.sv -----
// ----------------------------------------------------------------------------
// cptt_ctrl
// Sequencer for clear pass, three-probe lookup and displacement insert;
// holds the insert_rounds register.
// ----------------------------------------------------------------------------
module cptt_ctrl
    import cptt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ROUNDS_W-1:0] cfg_data,
    output cmd_t                cmd,
    input  sts_t                sts
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LK    = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_OVF   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          w_reg, w_next;
    logic [ROUNDS_W-1:0] round_reg, round_next;
    logic [ROUNDS_W-1:0] rounds_reg, rounds_next;

    assign cfg_ready   = 1'b1;
    assign rounds_next = (cfg_valid && cfg_ready) ? cfg_data : rounds_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        w_next     = w_reg;
        round_next = round_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    w_next   = HASH_DIRECT;
                    if (sts.in_key_zero)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = RES_MISS;
                    end
                    else if (sts.in_op == OP_LOOKUP)
                    begin
                        state_next = S_LK;
                    end
                    else if (rounds_reg == '0)
                    begin
                        state_next = S_OVF;
                    end
                    else
                    begin
                        round_next = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_LK:
            begin
                cmd.rd_en = (w_reg != PROBE_END);
                cmd.probe = w_reg;
                if (w_reg != HASH_DIRECT && sts.key_match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_HIT;
                    state_next   = S_IDLE;
                end
                else if (w_reg == PROBE_END)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_MISS;
                    state_next   = S_IDLE;
                end
                else
                begin
                    w_next = w_reg + 2'd1;
                end
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.probe  = w_reg;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr_en = 1'b1;
                if (sts.slot_empty || sts.key_match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_OK;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.swap = 1'b1;
                    if (w_reg == HASH_MUL)
                    begin
                        w_next = HASH_DIRECT;
                        if (round_reg == rounds_reg - ROUNDS_W'(1))
                        begin
                            state_next = S_OVF;
                        end
                        else
                        begin
                            round_next = round_reg + ROUNDS_W'(1);
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        w_next     = w_reg + 2'd1;
                        state_next = S_RD;
                    end
                end
            end
            S_OVF:
            begin
                cmd.res_load = 1'b1;
                cmd.res_code = RES_OVF;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            w_reg      <= '0;
            round_reg  <= '0;
            rounds_reg <= ROUNDS_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            w_reg      <= w_next;
            round_reg  <= round_next;
            rounds_reg <= rounds_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- src/cuckoo_pointer_translation_table_core.sv -----
// ----------------------------------------------------------------------------
// cuckoo_pointer_translation_table_core
// Key-to-value table with three-hash cuckoo placement and overflow report.
// ----------------------------------------------------------------------------
// Usage:
//   A request (op, key, new_value) transfers at a clock edge with start high
//   and busy low. Each request gives one result on result, flagged by done
//   high for exactly one cycle; the receiver cannot stall it.
//   After reset the table runs a clearing pass over all TABLE_DEPTH slots
//   (1024 by default), one slot a cycle, with busy high. The user must write
//   the insert_rounds register (reset 5) over cfg_valid/cfg_ready/cfg_data
//   only while idle; the block does not enforce it. cfg_ready is always high.
//   Work from request transfer to the result:
//     key zero        : result loaded at once, with no slot read
//     lookup          : up to three probes, one slot read per cycle from the
//                       single-read-port slot memory
//     insert          : each displacement step reads a slot, then writes the
//                       same slot; overflow after insert_rounds rounds
//   busy is low in the cycle that done is high, so the next request may
//   transfer then; no request is taken while one is in flight.
// ----------------------------------------------------------------------------
module cuckoo_pointer_translation_table_core
    import cptt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT,
    parameter int KEY_BITS    = KEY_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  req_t                request,
    output logic                done,
    output rsp_t                result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ROUNDS_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    cptt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    cptt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request transfer left no work and no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.insert_ok && result.overflow)
                 && !(result.hit && (result.insert_ok || result.overflow)))
        else $error("conflicting result flags");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> (result.dropped_key != '0))
        else $error("overflow reported an empty entry");
`endif

endmodule
